>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file fca_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low reset disable.
`define FCA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fat chain allocator assertion failed");

// Same, on the block's own clock and reset.
`define FCA_ASSERT_CLK(label, prop) \
  `FCA_ASSERT(label, clk_i, rst_ni, prop)

`endif

>>> hw/rtl/fca_pkg.sv
// ----------------------------------------------------------------------------
// fca_pkg
// Types, sizes and codes for the block allocation table chain allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fca_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned ENTRY_W     = 16;
  localparam int unsigned BLK_W       = 10;
  // scan counter must reach one past the last index
  localparam int unsigned CNT_W       = ((IDX_W > BLK_W) ? IDX_W : BLK_W) + 1;

  localparam logic [ENTRY_W-1:0] FREE_MARK = 16'd0;
  localparam logic [ENTRY_W-1:0] END_MARK  = 16'hFFFF;

  localparam logic [BLK_W-1:0] RESET_LOWEST  = 10'd5;
  localparam logic [BLK_W-1:0] RESET_HIGHEST = 10'd999;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST = 2'd1;

  localparam int unsigned IN_TDATA_W  = ((2 * BLK_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((BLK_W + 7) / 8) * 8;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_SHORT = 2'd1,
    STAT_NONE  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC,
    ST_ALLOC_END,
    ST_FREE_RD,
    ST_FREE_CHK,
    ST_RESP
  } state_e;

  typedef struct packed {
    mode_e            mode;
    logic [BLK_W-1:0] block_count;
    logic [BLK_W-1:0] start_block;
  } item_t;

  typedef struct packed {
    logic [BLK_W-1:0] lowest;
    logic [BLK_W-1:0] highest;
  } cfg_t;

  typedef struct packed {
    logic [BLK_W-1:0] first_block;
    status_e          status;
  } result_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } ram_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/fca_ram.sv
// ----------------------------------------------------------------------------
// fca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fca_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/fca_seq.sv
// ----------------------------------------------------------------------------
// fca_seq
// Sequencer for table clear, allocation scan and chain free walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fca_seq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire fca_pkg::item_t                item_i,
  input  wire fca_pkg::cfg_t                 cfg_i,
  output logic                               idle_o,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output fca_pkg::result_t                   res_o,
  output fca_pkg::ram_req_t                  ram_req_o,
  input  wire logic [fca_pkg::ENTRY_W-1:0]   ram_rdata_i
);

  localparam int unsigned IDX_W   = fca_pkg::IDX_W;
  localparam int unsigned CNT_W   = fca_pkg::CNT_W;
  localparam int unsigned BLK_W   = fca_pkg::BLK_W;
  localparam int unsigned ENTRY_W = fca_pkg::ENTRY_W;

  fca_pkg::state_e  state_q, state_d;
  fca_pkg::status_e status_q, status_d;

  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] hi_q, hi_d;
  logic             pend_v_q, pend_v_d;
  logic [IDX_W-1:0] pend_idx_q, pend_idx_d;
  logic [IDX_W-1:0] first_q, first_d;
  logic [IDX_W-1:0] last_q, last_d;
  logic             have_q, have_d;
  logic [BLK_W-1:0] got_q, got_d;
  logic [BLK_W-1:0] need_q, need_d;
  logic [IDX_W-1:0] steps_q, steps_d;

  logic             in_range;
  logic             hit;
  logic [BLK_W-1:0] got_inc;
  logic             fill_done;
  logic             scan_over;
  logic             walk_stop;
  logic             clear_last;
  logic             start_oob;
  logic [CNT_W-1:0] hi_clamp;

  // index and count compare / increment terms
  assign in_range   = (idx_q <= hi_q);
  assign hit        = pend_v_q && (ram_rdata_i == fca_pkg::FREE_MARK);
  assign got_inc    = BLK_W'(got_q + 1'b1);
  assign fill_done  = hit && (got_inc == need_q);
  assign scan_over  = !pend_v_q && !in_range;
  assign clear_last = (idx_q == CNT_W'(fca_pkg::TABLE_DEPTH - 1));
  assign start_oob  = (CNT_W'(item_i.start_block) >= CNT_W'(fca_pkg::TABLE_DEPTH));
  assign hi_clamp   = (CNT_W'(cfg_i.highest) > CNT_W'(fca_pkg::TABLE_DEPTH - 1))
                    ? CNT_W'(fca_pkg::TABLE_DEPTH - 1) : CNT_W'(cfg_i.highest);

  // walk ends on an end mark, a free entry, a link off the table or the step cap
  assign walk_stop = (ram_rdata_i == fca_pkg::END_MARK)
                  || (ram_rdata_i == fca_pkg::FREE_MARK)
                  || ({1'b0, ram_rdata_i} >= (ENTRY_W + 1)'(fca_pkg::TABLE_DEPTH))
                  || (steps_q == IDX_W'(fca_pkg::TABLE_DEPTH - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fca_pkg::ST_CLEAR: begin
        if (clear_last) begin
          state_d = fca_pkg::ST_IDLE;
        end
      end
      fca_pkg::ST_IDLE: begin
        if (start_i) begin
          if (item_i.mode == fca_pkg::MODE_ALLOC) begin
            state_d = (item_i.block_count == '0) ? fca_pkg::ST_RESP : fca_pkg::ST_ALLOC;
          end else begin
            state_d = start_oob ? fca_pkg::ST_RESP : fca_pkg::ST_FREE_RD;
          end
        end
      end
      fca_pkg::ST_ALLOC: begin
        if (fill_done) begin
          state_d = fca_pkg::ST_ALLOC_END;
        end else if (scan_over) begin
          state_d = have_q ? fca_pkg::ST_ALLOC_END : fca_pkg::ST_RESP;
        end
      end
      fca_pkg::ST_ALLOC_END: state_d = fca_pkg::ST_RESP;
      fca_pkg::ST_FREE_RD:   state_d = fca_pkg::ST_FREE_CHK;
      fca_pkg::ST_FREE_CHK: begin
        state_d = walk_stop ? fca_pkg::ST_RESP : fca_pkg::ST_FREE_RD;
      end
      fca_pkg::ST_RESP: begin
        if (res_ready_i) begin
          state_d = fca_pkg::ST_IDLE;
        end
      end
      default: state_d = fca_pkg::ST_IDLE;
    endcase
  end

  // datapath and table port
  always_comb begin
    idx_d      = idx_q;
    hi_d       = hi_q;
    pend_v_d   = pend_v_q;
    pend_idx_d = pend_idx_q;
    first_d    = first_q;
    last_d     = last_q;
    have_d     = have_q;
    got_d      = got_q;
    need_d     = need_q;
    steps_d    = steps_q;
    status_d   = status_q;

    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = last_q;
    ram_req_o.wdata = fca_pkg::FREE_MARK;
    ram_req_o.raddr = idx_q[IDX_W-1:0];

    case (state_q)
      fca_pkg::ST_CLEAR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = idx_q[IDX_W-1:0];
        idx_d           = clear_last ? '0 : CNT_W'(idx_q + 1'b1);
      end
      fca_pkg::ST_IDLE: begin
        if (start_i) begin
          idx_d    = (item_i.mode == fca_pkg::MODE_ALLOC) ? CNT_W'(cfg_i.lowest)
                                                          : CNT_W'(item_i.start_block);
          hi_d     = hi_clamp;
          pend_v_d = 1'b0;
          first_d  = '0;
          have_d   = 1'b0;
          got_d    = '0;
          need_d   = item_i.block_count;
          steps_d  = '0;
          status_d = ((item_i.mode == fca_pkg::MODE_ALLOC) && (item_i.block_count == '0))
                   ? fca_pkg::STAT_NONE : fca_pkg::STAT_DONE;
        end
      end
      fca_pkg::ST_ALLOC: begin
        // one read issued per cycle; data for the previous index checked now
        pend_v_d   = in_range;
        pend_idx_d = idx_q[IDX_W-1:0];
        if (in_range) begin
          idx_d = CNT_W'(idx_q + 1'b1);
        end
        if (hit) begin
          if (have_q) begin
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = last_q;
            ram_req_o.wdata = ENTRY_W'(pend_idx_q);
          end else begin
            first_d = pend_idx_q;
          end
          have_d = 1'b1;
          last_d = pend_idx_q;
          got_d  = got_inc;
        end else if (scan_over) begin
          status_d = have_q ? fca_pkg::STAT_SHORT : fca_pkg::STAT_NONE;
        end
      end
      fca_pkg::ST_ALLOC_END: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = last_q;
        ram_req_o.wdata = fca_pkg::END_MARK;
      end
      fca_pkg::ST_FREE_RD: begin
        ram_req_o.raddr = idx_q[IDX_W-1:0];
      end
      fca_pkg::ST_FREE_CHK: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = idx_q[IDX_W-1:0];
        if (!walk_stop) begin
          idx_d   = CNT_W'(ram_rdata_i[IDX_W-1:0]);
          steps_d = IDX_W'(steps_q + 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

  assign idle_o            = (state_q == fca_pkg::ST_IDLE);
  assign res_valid_o       = (state_q == fca_pkg::ST_RESP);
  assign res_o.first_block = BLK_W'(first_q);
  assign res_o.status      = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fca_pkg::ST_CLEAR;
      idx_q    <= '0;
      pend_v_q <= 1'b0;
      have_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      pend_v_q <= pend_v_d;
      have_q   <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q       <= hi_d;
    pend_idx_q <= pend_idx_d;
    first_q    <= first_d;
    last_q     <= last_d;
    got_q      <= got_d;
    need_q     <= need_d;
    steps_q    <= steps_d;
    status_q   <= status_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/fat_chain_allocator.sv
// ----------------------------------------------------------------------------
// fat_chain_allocator
// Block allocation table with chain allocate and chain free operations.
// ----------------------------------------------------------------------------
// After reset the table is swept to all-free, one entry per cycle, over all
// TABLE_DEPTH (1024) entries; no item is taken until then, while register
// writes are taken at any time. An allocate item scans the usable range
// through the table's single read port, one entry per cycle, and stops early
// when the wanted count is found; a zero count is answered without a scan. A
// free item walks the chain one link at a time, with a read state and a check
// state per link (each link's read must return before the next address is
// known). One item is in work at a time; the result sits in an output
// register so the next item may be taken while it waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fat_chain_allocator (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // input item stream
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  wire logic [fca_pkg::IN_TDATA_W-1:0]        s_axis_tdata,  // block_count, start_block
  input  wire logic                                  s_axis_tuser,  // mode
  // result stream
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  output logic      [fca_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // first_block
  output logic      [1:0]                            m_axis_tuser,  // status
  // register writes
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [fca_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [fca_pkg::BLK_W-1:0]             cfg_data_i
);

  localparam int unsigned BLK_W = fca_pkg::BLK_W;

  fca_pkg::cfg_t     cfg_q, cfg_d;
  fca_pkg::item_t    item;
  fca_pkg::result_t  res;
  fca_pkg::result_t  out_q, out_d;
  fca_pkg::ram_req_t ram_req;

  logic                        out_valid_q, out_valid_d;
  logic                        seq_idle;
  logic                        res_valid;
  logic                        res_ready;
  logic                        item_xfer;
  logic [fca_pkg::ENTRY_W-1:0] ram_rdata;

  assign item.mode        = fca_pkg::mode_e'(s_axis_tuser);
  assign item.block_count = s_axis_tdata[BLK_W-1:0];
  assign item.start_block = s_axis_tdata[2*BLK_W-1:BLK_W];

  assign s_axis_tready = seq_idle;
  assign item_xfer     = s_axis_tvalid && s_axis_tready;

  // register file
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        fca_pkg::CFG_LOWEST:  cfg_d.lowest  = cfg_data_i;
        fca_pkg::CFG_HIGHEST: cfg_d.highest = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = fca_pkg::OUT_TDATA_W'(out_q.first_block);
  assign m_axis_tuser  = out_q.status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lowest  <= fca_pkg::RESET_LOWEST;
      cfg_q.highest <= fca_pkg::RESET_HIGHEST;
      out_valid_q   <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  fca_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (item_xfer),
    .item_i      (item),
    .cfg_i       (cfg_q),
    .idle_o      (seq_idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  fca_ram #(
    .WIDTH (fca_pkg::ENTRY_W),
    .DEPTH (fca_pkg::TABLE_DEPTH)
  ) u_link_table (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

>>> hw/rtl/fca_checker.sv
// ----------------------------------------------------------------------------
// fca_checker
// Port-level checks for the chain allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fca_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [fca_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input wire logic [1:0]                        m_axis_tuser
);

  logic none_out;

  assign none_out = m_axis_tvalid && (m_axis_tuser == fca_pkg::STAT_NONE);

  property p_out_hold;
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser);
  endproperty

  // a stalled result holds
  `FCA_ASSERT_CLK(a_out_hold, p_out_hold)

  // status carries one of the three defined codes
  `FCA_ASSERT_CLK(a_status_code, m_axis_tvalid |-> m_axis_tuser <= fca_pkg::STAT_NONE)

  // nothing allocated means a zero block number
  `FCA_ASSERT_CLK(a_none_zero, none_out |-> m_axis_tdata == '0)

  // every item moves the sequencer out of idle, so input is closed right after a transfer
  `FCA_ASSERT_CLK(a_busy_after_xfer, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

endmodule

bind fat_chain_allocator fca_checker u_fca_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
